### design/gtb_pkg.sv
// shared types, constants and table-building functions for the gaussian tone burst generator
// depends on nothing; used by gtb_cfg, gtb_ctrl, gtb_datapath and the top level
`default_nettype none

package gtb_pkg;

  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] INV_E_Q30 = 64'd395007542;

  localparam int REG_SAMPLE_COUNT = 0;
  localparam int REG_FREQ_STEP = 1;
  localparam int REG_ENVELOPE_STEP = 2;
  localparam int REG_PLUS_AMPLITUDE = 3;
  localparam int REG_CROSS_AMPLITUDE = 4;

  typedef struct packed {
    logic [20:0] sample_count;
    logic [30:0] freq_step;
    logic [31:0] envelope_step;
    logic signed [31:0] plus_amplitude;
    logic signed [31:0] cross_amplitude;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_K,
    ST_U,
    ST_E,
    ST_ECAP,
    ST_ROM,
    ST_PC,
    ST_OP,
    ST_PS,
    ST_OC,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_PHASE,
    OP_K,
    OP_U,
    OP_E,
    OP_PC,
    OP_OP,
    OP_PS,
    OP_OC
  } mul_op_t;

  typedef struct packed {
    logic mul_en;
    mul_op_t op;
    logic start;
    logic cap_k;
    logic cap_big;
    logic cap_e;
    logic cap_plus;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [63:0] sin_div_by(input logic signed [63:0] x,
                                                   input int i);
    logic signed [63:0] q;
    case (i)
      0: q = x / 64'sd6;
      1: q = x / 64'sd20;
      2: q = x / 64'sd42;
      3: q = x / 64'sd72;
      4: q = x / 64'sd110;
      5: q = x / 64'sd156;
      6: q = x / 64'sd210;
      7: q = x / 64'sd272;
      8: q = x / 64'sd342;
      default: q = x;
    endcase
    return q;
  endfunction

  function automatic logic signed [63:0] cos_div_by(input logic signed [63:0] x,
                                                   input int i);
    logic signed [63:0] q;
    case (i)
      0: q = x / 64'sd2;
      1: q = x / 64'sd12;
      2: q = x / 64'sd30;
      3: q = x / 64'sd56;
      4: q = x / 64'sd90;
      5: q = x / 64'sd132;
      6: q = x / 64'sd182;
      7: q = x / 64'sd240;
      8: q = x / 64'sd306;
      default: q = x;
    endcase
    return q;
  endfunction

  function automatic logic [63:0] exp_div_by(input logic [63:0] x, input int n);
    logic [63:0] q;
    case (n)
      1: q = x / 64'd1;
      2: q = x / 64'd2;
      3: q = x / 64'd3;
      4: q = x / 64'd4;
      5: q = x / 64'd5;
      6: q = x / 64'd6;
      7: q = x / 64'd7;
      8: q = x / 64'd8;
      9: q = x / 64'd9;
      10: q = x / 64'd10;
      11: q = x / 64'd11;
      12: q = x / 64'd12;
      13: q = x / 64'd13;
      14: q = x / 64'd14;
      default: q = x;
    endcase
    return q;
  endfunction

  function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v < 0) begin
      c = 64'sd0;
    end else if (v > ONE_Q30) begin
      c = ONE_Q30;
    end else begin
      c = v;
    end
    return c;
  endfunction

  // packed {sin, cos} for a quantized turn fraction
  function automatic logic [63:0] sincos_entry(input logic [31:0] a);
    logic [63:0] x;
    logic signed [63:0] xs;
    logic signed [63:0] x2;
    logic signed [63:0] ts;
    logic signed [63:0] tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [63:0] sn;
    logic signed [63:0] cs;
    x = ({34'd0, a[29:0]} * HALF_PI_Q30) >> 30;
    xs = signed'(x);
    x2 = (xs * xs) >>> 30;
    ts = ONE_Q30;
    tc = ONE_Q30;
    for (int i = 8; i >= 0; i--) begin
      ts = ONE_Q30 - sin_div_by((x2 * ts) >>> 30, i);
      tc = ONE_Q30 - cos_div_by((x2 * tc) >>> 30, i);
    end
    s = clamp_unit((xs * ts) >>> 30);
    c = clamp_unit(tc);
    case (a[31:30])
      2'd0: begin
        sn = s;
        cs = c;
      end
      2'd1: begin
        sn = c;
        cs = -s;
      end
      2'd2: begin
        sn = -s;
        cs = -c;
      end
      default: begin
        sn = -c;
        cs = s;
      end
    endcase
    return {sn[31:0], cs[31:0]};
  endfunction

  // exp(-uq*uq/2) in q30 for a quantized envelope argument in q24
  function automatic logic [30:0] env_entry(input logic [26:0] uq);
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] r;
    v = ({37'd0, uq} * {37'd0, uq}) >> 25;
    m = v >> 24;
    f = v & 64'hFFFFFF;
    t = 64'd1073741824;
    for (int n = 14; n >= 1; n--) begin
      t = 64'd1073741824 + exp_div_by((f * t) >> 24, n);
    end
    num = (64'd1 << 60) + (t >> 1);
    rem = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= t) begin
        rem = rem - t;
        r[b] = 1'b1;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (64'(i) < m) begin
        r = (r * INV_E_Q30 + (64'd1 << 29)) >> 30;
      end
    end
    return r[30:0];
  endfunction

endpackage

`default_nettype wire

### design/gtb_cfg.sv
// apb-style configuration register file for the gaussian tone burst generator
// depends on gtb_pkg
`default_nettype none

module gtb_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output gtb_pkg::cfg_t     cfg
);

  gtb_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_sel;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count <= 21'd1024;
      cfg_r.freq_step <= '0;
      cfg_r.envelope_step <= '0;
      cfg_r.plus_amplitude <= '0;
      cfg_r.cross_amplitude <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        3'(gtb_pkg::REG_SAMPLE_COUNT): cfg_r.sample_count <= pwdata[20:0];
        3'(gtb_pkg::REG_FREQ_STEP): cfg_r.freq_step <= pwdata[30:0];
        3'(gtb_pkg::REG_ENVELOPE_STEP): cfg_r.envelope_step <= pwdata;
        3'(gtb_pkg::REG_PLUS_AMPLITUDE): cfg_r.plus_amplitude <= signed'(pwdata);
        3'(gtb_pkg::REG_CROSS_AMPLITUDE): cfg_r.cross_amplitude <= signed'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      3'(gtb_pkg::REG_SAMPLE_COUNT): prdata = {11'd0, cfg_r.sample_count};
      3'(gtb_pkg::REG_FREQ_STEP): prdata = {1'b0, cfg_r.freq_step};
      3'(gtb_pkg::REG_ENVELOPE_STEP): prdata = cfg_r.envelope_step;
      3'(gtb_pkg::REG_PLUS_AMPLITUDE): prdata = cfg_r.plus_amplitude;
      3'(gtb_pkg::REG_CROSS_AMPLITUDE): prdata = cfg_r.cross_amplitude;
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/gtb_ctrl.sv
// sequencing state machine: walks one request through the shared multiplier steps
// depends on gtb_pkg
`default_nettype none

module gtb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire gtb_pkg::status_t sts,
  output gtb_pkg::cmd_t         cmd
);

  gtb_pkg::state_t state_r;
  gtb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.op = gtb_pkg::OP_PHASE;
    in_stall = 1'b1;
    case (state_r)
      gtb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = gtb_pkg::ST_PHASE;
        end
      end
      gtb_pkg::ST_PHASE: begin
        cmd.mul_en = 1'b1;
        cmd.op = gtb_pkg::OP_PHASE;
        state_nxt = gtb_pkg::ST_K;
      end
      gtb_pkg::ST_K: begin
        cmd.mul_en = 1'b1;
        cmd.op = gtb_pkg::OP_K;
        state_nxt = gtb_pkg::ST_U;
      end
      gtb_pkg::ST_U: begin
        cmd.cap_k = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.op = gtb_pkg::OP_U;
        state_nxt = gtb_pkg::ST_E;
      end
      gtb_pkg::ST_E: begin
        cmd.cap_big = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.op = gtb_pkg::OP_E;
        state_nxt = gtb_pkg::ST_ECAP;
      end
      gtb_pkg::ST_ECAP: begin
        cmd.cap_e = 1'b1;
        state_nxt = gtb_pkg::ST_ROM;
      end
      gtb_pkg::ST_ROM: begin
        state_nxt = gtb_pkg::ST_PC;
      end
      gtb_pkg::ST_PC: begin
        cmd.mul_en = 1'b1;
        cmd.op = gtb_pkg::OP_PC;
        state_nxt = gtb_pkg::ST_OP;
      end
      gtb_pkg::ST_OP: begin
        cmd.mul_en = 1'b1;
        cmd.op = gtb_pkg::OP_OP;
        state_nxt = gtb_pkg::ST_PS;
      end
      gtb_pkg::ST_PS: begin
        cmd.cap_plus = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.op = gtb_pkg::OP_PS;
        state_nxt = gtb_pkg::ST_OC;
      end
      gtb_pkg::ST_OC: begin
        cmd.mul_en = 1'b1;
        cmd.op = gtb_pkg::OP_OC;
        state_nxt = gtb_pkg::ST_FIN;
      end
      gtb_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = gtb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gtb_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == gtb_pkg::ST_PHASE)
    else $error("accepted request did not start the sequence");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gtb_pkg::ST_FIN && !sts.out_free) |=> state_r == gtb_pkg::ST_FIN)
    else $error("finished sample left while output slot busy");

endmodule

`default_nettype wire

### design/gtb_datapath.sv
// datapath: position counter, shared multiplier, sine and envelope tables, output slot
// depends on gtb_pkg
`default_nettype none

module gtb_datapath #(
  parameter int INDEX_BITS = 20,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int ENVELOPE_TABLE_DEPTH = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire gtb_pkg::cfg_t           cfg,
  input  wire gtb_pkg::cmd_t           cmd,
  output gtb_pkg::status_t             sts,
  input  wire logic                    in_restart,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [31:0]           out_plus_sample,
  output logic signed [31:0]           out_cross_sample,
  output logic [INDEX_BITS-1:0]        out_sample_index,
  output logic                         out_last
);

  localparam int KB = $clog2(SINE_TABLE_DEPTH);
  localparam int EB = $clog2(ENVELOPE_TABLE_DEPTH);
  localparam logic [31:0] MAX_N = 32'd1 << INDEX_BITS;

  logic [63:0] sin_tbl [SINE_TABLE_DEPTH];
  logic [30:0] env_tbl [ENVELOPE_TABLE_DEPTH];

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_sin
    localparam logic [31:0] A = 32'((64'(gi) << 32) / SINE_TABLE_DEPTH);
    localparam logic [63:0] V = gtb_pkg::sincos_entry(A);
    assign sin_tbl[gi] = V;
  end

  for (genvar gi = 0; gi < ENVELOPE_TABLE_DEPTH; gi++) begin : g_env
    localparam logic [26:0] UQ = 27'((64'(gi) << 27) / ENVELOPE_TABLE_DEPTH);
    localparam logic [30:0] V = gtb_pkg::env_entry(UQ);
    assign env_tbl[gi] = V;
  end

  logic [INDEX_BITS-1:0]      position_r;
  logic [INDEX_BITS-1:0]      pos_use;
  logic [31:0]                cnt_even;
  logic [31:0]                n_len;
  logic [31:0]                d_full;
  logic [31:0]                mag_full;
  logic                       last_nxt;
  logic signed [INDEX_BITS+1:0] d_r;
  logic [INDEX_BITS:0]        mag_r;
  logic [INDEX_BITS-1:0]      index_r;
  logic                       last_r;
  logic [KB-1:0]              k_r;
  logic [EB-1:0]              e_r;
  logic                       big_r;
  logic [63:0]                sc_r;
  logic [30:0]                env_rd_r;
  logic [30:0]                env_q;
  logic signed [32:0]         mul_a;
  logic signed [32:0]         mul_b;
  logic signed [65:0]         prod_r;
  logic signed [65:0]         rnd;
  logic signed [31:0]         rnd_sat;
  logic signed [31:0]         plus_res_r;
  logic                       out_valid_r;
  logic signed [31:0]         out_plus_r;
  logic signed [31:0]         out_cross_r;
  logic [INDEX_BITS-1:0]      out_index_r;
  logic                       out_last_r;

  // record length, centre offset and its magnitude, and the last flag
  always_comb begin
    pos_use = in_restart ? '0 : position_r;
    cnt_even = {11'd0, cfg.sample_count[20:1], 1'b0};
    if (cnt_even < 32'd2) begin
      n_len = 32'd2;
    end else if (cnt_even > MAX_N) begin
      n_len = MAX_N;
    end else begin
      n_len = cnt_even;
    end
    d_full = 32'(pos_use) - (n_len >> 1);
    mag_full = d_full[31] ? -d_full : d_full;
    last_nxt = 32'(pos_use) >= (n_len - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
    end else if (cmd.start) begin
      position_r <= last_nxt ? '0 : pos_use + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      d_r <= signed'(d_full[INDEX_BITS+1:0]);
      mag_r <= mag_full[INDEX_BITS:0];
      index_r <= pos_use;
      last_r <= last_nxt;
    end
  end

  assign env_q = big_r ? '0 : env_rd_r;

  always_comb begin
    case (cmd.op)
      gtb_pkg::OP_PHASE: begin
        mul_a = 33'(d_r);
        mul_b = signed'({2'b00, cfg.freq_step});
      end
      gtb_pkg::OP_K: begin
        mul_a = signed'({1'b0, prod_r[31:0]});
        mul_b = 33'(SINE_TABLE_DEPTH);
      end
      gtb_pkg::OP_U: begin
        mul_a = signed'(33'(mag_r));
        mul_b = signed'({1'b0, cfg.envelope_step});
      end
      gtb_pkg::OP_E: begin
        mul_a = signed'({6'd0, prod_r[26:0]});
        mul_b = 33'(ENVELOPE_TABLE_DEPTH);
      end
      gtb_pkg::OP_PC: begin
        mul_a = signed'({2'b00, env_q});
        mul_b = 33'(signed'(sc_r[31:0]));
      end
      gtb_pkg::OP_OP: begin
        mul_a = 33'(cfg.plus_amplitude);
        mul_b = rnd[32:0];
      end
      gtb_pkg::OP_PS: begin
        mul_a = signed'({2'b00, env_q});
        mul_b = 33'(signed'(sc_r[63:32]));
      end
      gtb_pkg::OP_OC: begin
        mul_a = 33'(cfg.cross_amplitude);
        mul_b = rnd[32:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up at q30, then saturate
  always_comb begin
    rnd = (prod_r + 66'sd536870912) >>> 30;
    if (rnd > 66'sd2147483647) begin
      rnd_sat = 32'sh7FFFFFFF;
    end else if (rnd < -66'sd2147483648) begin
      rnd_sat = 32'sh80000000;
    end else begin
      rnd_sat = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.cap_k) begin
      k_r <= prod_r[32 +: KB];
    end
    if (cmd.cap_big) begin
      big_r <= prod_r[65:27] != '0;
    end
    if (cmd.cap_e) begin
      e_r <= prod_r[27 +: EB];
    end
    if (cmd.cap_plus) begin
      plus_res_r <= rnd_sat;
    end
    sc_r <= sin_tbl[k_r];
    env_rd_r <= env_tbl[e_r];
  end

  // output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_plus_r <= plus_res_r;
      out_cross_r <= rnd_sat;
      out_index_r <= index_r;
      out_last_r <= last_r;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_plus_sample = out_plus_r;
  assign out_cross_sample = out_cross_r;
  assign out_sample_index = out_index_r;
  assign out_last = out_last_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output slot overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded sample not presented");

endmodule

`default_nettype wire

### design/gaussian_tone_burst_generator_unit.sv
// gaussian tone burst generator: sample source for a gaussian-enveloped tone burst
// usage:
//   input channel (in_valid / in_stall / in_restart): each request asks for the next
//   sample; in_restart high restarts the record at sample zero
//   output channel (out_valid / out_stall): one sample pair per request, with the
//   sample's index in the record and a last flag on the final sample
//   configuration: apb-style port, registers at byte offsets 0x0 sample_count,
//   0x4 freq_step, 0x8 envelope_step, 0xc plus_amplitude, 0x10 cross_amplitude;
//   write only while idle
// latency: result shows 11 cycles after the request is accepted
// throughput: one sample every 12 cycles, set by the eight steps that share the
//   single 33x33 multiplier plus the registered table reads
// reset: position returns to zero and registers take their reset values
// a stalled result stays in the output register; the next request can be taken
//   meanwhile and finishes once the slot frees up
// depends on gtb_pkg, gtb_cfg, gtb_ctrl, gtb_datapath
`default_nettype none

module gaussian_tone_burst_generator_unit #(
  parameter int INDEX_BITS = 20,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int ENVELOPE_TABLE_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_restart,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [31:0]         out_plus_sample,
  output logic signed [31:0]         out_cross_sample,
  output logic [INDEX_BITS-1:0]      out_sample_index,
  output logic                       out_last,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [4:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  gtb_pkg::cfg_t    cfg;
  gtb_pkg::cmd_t    cmd;
  gtb_pkg::status_t sts;

  gtb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  gtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtb_datapath #(
    .INDEX_BITS           (INDEX_BITS),
    .SINE_TABLE_DEPTH     (SINE_TABLE_DEPTH),
    .ENVELOPE_TABLE_DEPTH (ENVELOPE_TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plus_sample  (out_plus_sample),
    .out_cross_sample (out_cross_sample),
    .out_sample_index (out_sample_index),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

### dv/gtb_checker.sv
// checker for the gaussian tone burst generator: watches the config port and both channels,
// predicts each sample pair and compares it; depends on gtb_pkg for register indexes
`timescale 1ns / 1ps

module gtb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_restart,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_plus_sample,
  input  logic signed [31:0] out_cross_sample,
  input  logic [19:0]        out_sample_index,
  input  logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 samples_due
);

  localparam logic signed [63:0] UNIT = 64'sd1073741824;
  localparam logic signed [63:0] HALF = 64'sd536870912;

  typedef struct packed {
    logic signed [31:0] plus_sample;
    logic signed [31:0] cross_sample;
    logic [19:0]        sample_index;
    logic               last;
  } burst_sample_t;

  logic [20:0]        sample_count;
  logic [30:0]        freq_step;
  logic [31:0]        envelope_step;
  logic signed [31:0] plus_amp;
  logic signed [31:0] cross_amp;
  logic [19:0]        position;
  burst_sample_t      sample_queue[$];

  function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + HALF;
    return s >>> 30;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] unit_clip(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v < 0) r = 0;
    else if (v > UNIT) r = UNIT;
    else r = v;
    return r;
  endfunction

  // gaussian envelope in q30 for q24 argument u
  function automatic logic signed [63:0] gauss_env(input logic [63:0] u);
    logic [63:0] uq, v, m, f, t, r;
    if (u >> 27 != 0) return 0;
    uq = {u[26:17], 17'd0};
    v = (uq * uq) >> 25;
    m = v >> 24;
    f = v & 64'hffffff;
    t = 64'd1073741824;
    for (int n = 14; n >= 1; n--) t = 64'd1073741824 + ((f * t) >> 24) / 64'(n);
    r = ((64'd1 << 60) + t / 2) / t;
    for (int i = 0; i < 32; i++)
      if (64'(i) < m) r = (r * 64'd395007542 + (64'd1 << 29)) >> 30;
    return signed'(r);
  endfunction

  function automatic burst_sample_t next_sample(input logic [19:0] pos);
    burst_sample_t res;
    logic [63:0] n, half, mag, prod, x;
    logic [31:0] ph;
    logic signed [63:0] d, xs, x2, ts, tc, s, c, sn, cs, env, p;
    n = {43'd0, sample_count[20:1], 1'b0};
    if (n < 2) n = 2;
    if (n > 64'd1048576) n = 64'd1048576;
    half = n / 2;
    d = signed'({44'd0, pos}) - signed'(half);
    mag = (d < 0) ? unsigned'(-d) : unsigned'(d);
    prod = unsigned'(d) * {33'd0, freq_step};
    ph = prod[31:0];
    x = ({34'd0, ph[29:22], 22'd0} * 64'd1686629713) >> 30;
    xs = signed'(x);
    x2 = (xs * xs) >>> 30;
    ts = UNIT;
    tc = UNIT;
    for (int i = 8; i >= 0; i--) begin
      ts = UNIT - ((x2 * ts) >>> 30) / (64'sd4 * (i + 1) * (i + 1) + 64'sd2 * (i + 1));
      tc = UNIT - ((x2 * tc) >>> 30) / (64'sd4 * (i + 1) * (i + 1) - 64'sd2 * (i + 1));
    end
    s = unit_clip((xs * ts) >>> 30);
    c = unit_clip(tc);
    case (ph[31:30])
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    env = gauss_env(mag * {32'd0, envelope_step});
    p = rnd_q30(env * cs);
    res.plus_sample = sat32(rnd_q30(64'(plus_amp) * p));
    p = rnd_q30(env * sn);
    res.cross_sample = sat32(rnd_q30(64'(cross_amp) * p));
    res.sample_index = pos;
    res.last = {44'd0, pos} >= n - 1;
    return res;
  endfunction

  always @(posedge clk) begin
    burst_sample_t want;
    logic [19:0] pos;
    int errs;
    errs = 0;
    if (!rst_n) begin
      sample_count = 21'd1024;
      freq_step = 0;
      envelope_step = 0;
      plus_amp = 0;
      cross_amp = 0;
      position = 0;
      sample_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (int'(cfg_paddr >> 2))
          gtb_pkg::REG_SAMPLE_COUNT: sample_count = cfg_pwdata[20:0];
          gtb_pkg::REG_FREQ_STEP: freq_step = cfg_pwdata[30:0];
          gtb_pkg::REG_ENVELOPE_STEP: envelope_step = cfg_pwdata;
          gtb_pkg::REG_PLUS_AMPLITUDE: plus_amp = cfg_pwdata;
          gtb_pkg::REG_CROSS_AMPLITUDE: cross_amp = cfg_pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pos = in_restart ? 20'd0 : position;
        want = next_sample(pos);
        sample_queue.push_back(want);
        position = want.last ? 20'd0 : pos + 20'd1;
      end
      if (out_valid && !out_stall) begin
        if (sample_queue.size() == 0) begin
          $error("unexpected sample at index %0d", out_sample_index);
          errs++;
        end else begin
          want = sample_queue.pop_front();
          if (want.plus_sample !== out_plus_sample) begin
            $error("plus_sample: expected %0d, got %0d", want.plus_sample, out_plus_sample);
            errs++;
          end
          if (want.cross_sample !== out_cross_sample) begin
            $error("cross_sample: expected %0d, got %0d", want.cross_sample, out_cross_sample);
            errs++;
          end
          if (want.sample_index !== out_sample_index) begin
            $error("sample_index: expected %0d, got %0d", want.sample_index, out_sample_index);
            errs++;
          end
          if (want.last !== out_last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    samples_due <= sample_queue.size();
  end

endmodule

### dv/testbench.sv
// top of the gaussian tone burst generator testbench: clock, reset, register writes,
// request and stall stimulus and the verdict; depends on gtb_pkg and gtb_checker
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_restart;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_plus_sample;
  logic signed [31:0] out_cross_sample;
  logic [19:0]        out_sample_index;
  logic               out_last;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [4:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;
  int                 fail_count;
  int                 samples_due;
  int                 cycle_count;

  gaussian_tone_burst_generator_unit DUT (.*);

  gtb_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_restart, .out_valid, .out_stall,
    .out_plus_sample, .out_cross_sample, .out_sample_index, .out_last,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .samples_due
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver stalls: random pattern, quiet stretches, one long hold-off
  initial begin
    int mode;
    int span;
    bit held;
    held = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!held && cycle_count > 4000) begin
        held = 1;
        out_stall <= 1;
        repeat (500) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 40);
      repeat (span) begin
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= $urandom_range(0, 1);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] value);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= 5'(idx * 4);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic request(input logic restart);
    in_valid <= 1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_bursts(input int count, input int restart_odds);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) request($urandom_range(0, restart_odds) == 0);
      left -= burst;
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        in_restart <= $urandom_range(0, 1);
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    in_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    repeat (2) @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_all(input logic [31:0] count, input logic [31:0] freq,
                         input logic [31:0] env, input logic [31:0] pa,
                         input logic [31:0] ca);
    write_reg(gtb_pkg::REG_SAMPLE_COUNT, count);
    write_reg(gtb_pkg::REG_FREQ_STEP, freq);
    write_reg(gtb_pkg::REG_ENVELOPE_STEP, env);
    write_reg(gtb_pkg::REG_PLUS_AMPLITUDE, pa);
    write_reg(gtb_pkg::REG_CROSS_AMPLITUDE, ca);
  endtask

  initial begin
    logic [31:0] cnt;
    rst_n = 0;
    in_valid = 0;
    in_restart = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings, then restart mid record
    repeat (3) request(0);
    request(1);
    request(0);
    drain();
    set_all(32'd8, 32'h7fffffff, 32'h0100_0000, 32'h8000_0000, 32'h7fffffff);
    write_reg(5, 32'hffffffff);
    write_reg(7, 32'h0);
    repeat (10) request(0);
    request(1);
    drain();
    // odd, tiny and oversized counts
    set_all(32'd1, 32'h4000_0000, 32'hffffffff, 32'h4000_0000, 32'hc000_0000);
    repeat (3) request(0);
    drain();
    write_reg(gtb_pkg::REG_SAMPLE_COUNT, 32'd7);
    repeat (3) request(0);
    drain();
    set_all(32'h001f_ffff, 32'h1234_5678, 32'h0000_0200, 32'h7fffffff, 32'h8000_0000);
    repeat (3) request(1);
    request(0);
    drain();
    // count lowered mid record, with the position still inside the shorter record
    write_reg(gtb_pkg::REG_SAMPLE_COUNT, 32'd4);
    request(0);
    request(0);
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      case ($urandom_range(0, 7))
        0: cnt = $urandom;
        1: cnt = 32'd1048576;
        2: cnt = $urandom_range(0, 1);
        default: cnt = $urandom_range(2, 80);
      endcase
      set_all(cnt,
              ($urandom_range(0, 4) == 0) ? 32'h7fffffff : $urandom,
              ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 1 << 23)) << $urandom_range(0, 4)
                                          : $urandom,
              ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : $urandom,
              ($urandom_range(0, 3) == 0) ? 32'h7fffffff : $urandom);
      run_bursts(170, $urandom_range(4, 60));
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### gaussian_tone_burst_generator_unit.f
design/gtb_pkg.sv
design/gtb_cfg.sv
design/gtb_ctrl.sv
design/gtb_datapath.sv
design/gaussian_tone_burst_generator_unit.sv
dv/gtb_checker.sv
dv/testbench.sv
